// ===== hw/rtl/gol_pkg.sv =====
// Shared types, constants and codes for the life grid stepper.
package gol_pkg;

   localparam int ROW_BITS         = 64;
   localparam int COL_IDX_W        = 6;
   localparam int FIELD_W          = 7;
   localparam int MAX_SIDE_DEFAULT = 64;

   localparam logic [FIELD_W-1:0] SIDE_RESET = 7'd64;

   // B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      CMD_TOGGLE = 2'd0,
      CMD_STEP   = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_IGNORED  = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGL,
      ST_READ,
      ST_STEP_LOAD,
      ST_STEP_ROW,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/gol_grid_mem.sv =====
// Row memory of the cell grid with per-row valid bits so unwritten rows read dead.
module gol_grid_mem #(
   parameter int DEPTH  = gol_pkg::MAX_SIDE_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [gol_pkg::ROW_BITS-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [gol_pkg::ROW_BITS-1:0] wr_data
);

   logic [gol_pkg::ROW_BITS-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]             valid_ff;
   logic [gol_pkg::ROW_BITS-1:0] rd_word_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // a row never written holds dead cells
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== hw/rtl/gol_row_unit.sv =====
// Next-generation row from three masked neighbor rows under the B3/S23 rule.
module gol_row_unit (
   input  logic [gol_pkg::ROW_BITS-1:0] up_row,
   input  logic [gol_pkg::ROW_BITS-1:0] mid_row,
   input  logic [gol_pkg::ROW_BITS-1:0] dn_row,
   output logic [gol_pkg::ROW_BITS-1:0] next_row
);

   always_comb begin
      logic [gol_pkg::ROW_BITS+1:0] up_p;
      logic [gol_pkg::ROW_BITS+1:0] mid_p;
      logic [gol_pkg::ROW_BITS+1:0] dn_p;
      logic [3:0]                   cnt;
      // pad with dead cells on both edges
      up_p  = {1'b0, up_row, 1'b0};
      mid_p = {1'b0, mid_row, 1'b0};
      dn_p  = {1'b0, dn_row, 1'b0};
      next_row = '0;
      for (int c = 0; c < gol_pkg::ROW_BITS; c++) begin
         cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
             + 4'(mid_p[c]) + 4'(mid_p[c+2])
             + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
         next_row[c] = (cnt == gol_pkg::BIRTH_COUNT)
                    || (mid_row[c] && (cnt == gol_pkg::SURVIVE_COUNT));
      end
   end

endmodule

// ===== hw/rtl/life_automaton_grid_step.sv =====
// Top level of the life grid stepper: sequencer, result register and assertions.
//
// Requests arrive on req_valid/req_stall with req_cmd, req_col and req_row;
// every request yields exactly one result on rsp_valid/rsp_stall carrying
// rsp_status, rsp_cell_value and rsp_row_bits. csr_wr_en/csr_wr_data set
// the active grid side; the user must write it only while no request is
// in flight, which the block does not enforce. A toggle or a read goes
// through ST_TGL or ST_READ and then ST_DONE; a rejected or ignored one
// goes straight to ST_DONE. A step sweeps the active rows one per cycle
// through the shared row unit, with the rows above and at the current row
// held in registers and the row below read ahead from the row memory.
// One request is worked on at a time; req_stall is high until the result
// is placed in the output register. A result waiting on a stalled
// receiver does not block the next request, but the sequencer holds its
// finished result until the output register frees up.
// Reset clears the side to 64 and marks every row dead through per-row
// valid bits, so the block takes requests in the first cycle after reset.
module life_automaton_grid_step #(
   parameter int MAX_SIDE = gol_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [gol_pkg::FIELD_W-1:0]   req_col,
   input  logic [gol_pkg::FIELD_W-1:0]   req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_cell_value,
   output logic [gol_pkg::ROW_BITS-1:0]  rsp_row_bits,
   input  logic                          csr_wr_en,
   input  logic [gol_pkg::FIELD_W-1:0]   csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_SIDE);
   localparam int CNT_W  = $clog2(MAX_SIDE + 2);

   gol_pkg::state_type state_ff, state_in;

   logic [gol_pkg::FIELD_W-1:0]   grid_side_ff;
   logic [CNT_W-1:0]              row_ff, row_in;
   logic [gol_pkg::COL_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [gol_pkg::ROW_BITS-1:0]  up_ff, up_in;
   logic [gol_pkg::ROW_BITS-1:0]  mid_ff, mid_in;
   logic [1:0]                    res_status_ff, res_status_in;
   logic                          res_cell_ff, res_cell_in;
   logic [gol_pkg::ROW_BITS-1:0]  res_bits_ff, res_bits_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic                          rsp_cell_ff, rsp_cell_in;
   logic [gol_pkg::ROW_BITS-1:0]  rsp_bits_ff, rsp_bits_in;

   logic [CNT_W-1:0]              side_act;
   logic [gol_pkg::FIELD_W-1:0]   side_wide;
   logic [gol_pkg::ROW_BITS-1:0]  side_mask;
   logic [CNT_W-1:0]              row_p1;
   logic [CNT_W-1:0]              row_p2;
   logic [gol_pkg::ROW_BITS-1:0]  dn_word;
   logic [gol_pkg::ROW_BITS-1:0]  next_row;
   logic [gol_pkg::ROW_BITS-1:0]  tgl_word;
   logic [gol_pkg::FIELD_W-1:0]   req_row_m1;

   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic [gol_pkg::ROW_BITS-1:0]  rd_data;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [gol_pkg::ROW_BITS-1:0]  wr_data;

   gol_grid_mem #(
      .DEPTH  (MAX_SIDE),
      .ADDR_W (ADDR_W)
   ) u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   gol_row_unit u_row_unit (
      .up_row   (up_ff & side_mask),
      .mid_row  (mid_ff & side_mask),
      .dn_row   (dn_word & side_mask),
      .next_row (next_row)
   );

   // clamp the side register into 1..MAX_SIDE
   always_comb begin
      if (grid_side_ff == '0) begin
         side_act = CNT_W'(1);
      end else if (grid_side_ff > gol_pkg::FIELD_W'(MAX_SIDE)) begin
         side_act = CNT_W'(MAX_SIDE);
      end else begin
         side_act = grid_side_ff[CNT_W-1:0];
      end
   end

   assign side_wide = gol_pkg::FIELD_W'(side_act);

   always_comb begin
      for (int k = 0; k < gol_pkg::ROW_BITS; k++) begin
         side_mask[k] = (k < int'(side_act));
      end
   end

   assign row_p1     = row_ff + CNT_W'(1);
   assign row_p2     = row_ff + CNT_W'(2);
   assign dn_word    = (row_p1 < side_act) ? rd_data : '0;
   assign tgl_word   = rd_data ^ (gol_pkg::ROW_BITS'(1) << bit_idx_ff);
   assign req_row_m1 = req_row - gol_pkg::FIELD_W'(1);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      bit_idx_in    = bit_idx_ff;
      up_in         = up_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_cell_in   = res_cell_ff;
      res_bits_in   = res_bits_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_bits_in   = rsp_bits_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      req_stall     = (state_ff != gol_pkg::ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         gol_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_status_in = gol_pkg::STATUS_DONE;
               res_cell_in   = 1'b0;
               res_bits_in   = '0;
               row_in        = req_row_m1[CNT_W-1:0];
               bit_idx_in    = req_col[gol_pkg::COL_IDX_W-1:0]
                             - gol_pkg::COL_IDX_W'(1);
               state_in      = gol_pkg::ST_DONE;
               case (req_cmd)
                  gol_pkg::CMD_TOGGLE: begin
                     if (req_col == '0 || req_row == '0) begin
                        res_status_in = gol_pkg::STATUS_IGNORED;
                     end else if (req_col > side_wide || req_row > side_wide) begin
                        res_status_in = gol_pkg::STATUS_REJECTED;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_row_m1[ADDR_W-1:0];
                        state_in = gol_pkg::ST_TGL;
                     end
                  end
                  gol_pkg::CMD_READ: begin
                     if (req_row == '0) begin
                        res_status_in = gol_pkg::STATUS_IGNORED;
                     end else if (req_row > side_wide) begin
                        res_status_in = gol_pkg::STATUS_REJECTED;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_row_m1[ADDR_W-1:0];
                        state_in = gol_pkg::ST_READ;
                     end
                  end
                  gol_pkg::CMD_STEP: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     row_in   = '0;
                     up_in    = '0;
                     state_in = gol_pkg::ST_STEP_LOAD;
                  end
                  default: begin
                     res_status_in = gol_pkg::STATUS_IGNORED;
                  end
               endcase
            end
         end
         gol_pkg::ST_TGL: begin
            wr_en       = 1'b1;
            wr_addr     = row_ff[ADDR_W-1:0];
            wr_data     = tgl_word;
            res_cell_in = tgl_word[bit_idx_ff];
            state_in    = gol_pkg::ST_DONE;
         end
         gol_pkg::ST_READ: begin
            res_bits_in = rd_data & side_mask;
            state_in    = gol_pkg::ST_DONE;
         end
         gol_pkg::ST_STEP_LOAD: begin
            mid_in = rd_data;
            if (side_act > CNT_W'(1)) begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(1);
            end
            state_in = gol_pkg::ST_STEP_ROW;
         end
         gol_pkg::ST_STEP_ROW: begin
            // write back this row, keep cells outside the side untouched
            wr_en   = 1'b1;
            wr_addr = row_ff[ADDR_W-1:0];
            wr_data = (mid_ff & ~side_mask) | (next_row & side_mask);
            up_in   = mid_ff;
            mid_in  = dn_word;
            if (row_p2 < side_act) begin
               rd_en   = 1'b1;
               rd_addr = row_p2[ADDR_W-1:0];
            end
            row_in = row_p1;
            if (row_p1 == side_act) begin
               state_in = gol_pkg::ST_DONE;
            end
         end
         gol_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cell_in   = res_cell_ff;
               rsp_bits_in   = res_bits_ff;
               state_in      = gol_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gol_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gol_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         grid_side_ff <= gol_pkg::SIDE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            grid_side_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      bit_idx_ff    <= bit_idx_in;
      up_ff         <= up_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_cell_ff   <= res_cell_in;
      res_bits_ff   <= res_bits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_bits_ff   <= rsp_bits_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_row_bits   = rsp_bits_ff;

   a_no_write_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gol_pkg::ST_IDLE || state_ff == gol_pkg::ST_DONE) |-> !wr_en)
      else $error("grid written outside a request");

   a_sweep_in_side : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gol_pkg::ST_STEP_ROW) |-> (row_ff < side_act))
      else $error("step sweep ran past the active side");

   a_fail_no_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != gol_pkg::STATUS_DONE)
         |-> (!rsp_cell_ff && rsp_bits_ff == '0))
      else $error("failed request returned data");

   a_bits_in_side : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gol_pkg::ST_READ) |=> ((res_bits_ff & ~side_mask) == '0))
      else $error("row read returned cells beyond the side");

endmodule
